>>> design/centroid_cross_segment_snap_defines.svh
// Assertion macros shared by the centroid cross segment snap design.
`ifndef CENTROID_CROSS_SEGMENT_SNAP_DEFINES_SVH
`define CENTROID_CROSS_SEGMENT_SNAP_DEFINES_SVH
`ifndef SYNTHESIS
`define CCS_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define CCS_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define CCS_ASSERT(label, clk, rst_n, prop, msg)
`define CCS_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

>>> design/ccs_pkg.sv
// ----------------------------------------------------------------------------
// ccs_pkg
// Shared constants, types and the sine table function for the snap block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package ccs_pkg;

  localparam int unsigned MaxPointsDef = 1024;
  localparam int unsigned SineDepthDef = 256;
  localparam int unsigned CoordW = 32;
  localparam int unsigned HeadingW = 16;
  localparam int unsigned HalfLenW = 24;
  localparam int unsigned SumW = 64;
  localparam logic [0:0] RegHeading = 1'b0;
  localparam logic [0:0] RegHalfLen = 1'b1;
  localparam logic [63:0] PiQ30 = 64'd3373259426;

  typedef struct packed {
    logic start;
    logic busy;
  } div_ctrl_t;

  // Sine of a quarter-wave angle u (0..16384), Q1.16, from an 8-term series.
  function automatic logic [16:0] quarter_sin(input logic [14:0] u);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic signed [63:0] acc;
    logic [63:0] r;
    x = (64'(u) * PiQ30) >> 15;
    x2 = (x * x) >> 30;
    term = x;
    acc = signed'(x);
    for (int n = 1; n <= 7; n++) begin
      term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) acc = acc - signed'(term);
      else acc = acc + signed'(term);
    end
    if (acc < 0) acc = 0;
    r = (unsigned'(acc) + 64'd8192) >> 14;
    if (r > 64'd65536) r = 64'd65536;
    return r[16:0];
  endfunction

  function automatic logic signed [17:0] sin16(input logic [15:0] a);
    logic [16:0] m;
    if (a[14]) m = quarter_sin(15'(17'd16384 - 17'(a[13:0])));
    else m = quarter_sin({1'b0, a[13:0]});
    return a[15] ? -$signed({1'b0, m}) : $signed({1'b0, m});
  endfunction

  // Entry idx of a Depth-entry full-turn sine table, for constant arguments.
  function automatic logic signed [17:0] sine_entry(input int unsigned idx,
                                                    input int unsigned Depth);
    logic [31:0] t;
    t = (32'(idx) * 32'd65536) / Depth;
    return sin16(t[15:0]);
  endfunction

endpackage
`default_nettype wire

>>> design/ccs_ram.sv
// ----------------------------------------------------------------------------
// ccs_ram
// Generic single-port RAM with a registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module ccs_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]              rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[addr_i] <= wdata_i;
    rdata_o <= mem_q[addr_i];
  end
endmodule
`default_nettype wire

>>> design/ccs_div.sv
// ----------------------------------------------------------------------------
// ccs_div
// Restoring divider, one quotient bit per cycle, magnitude in and out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "centroid_cross_segment_snap_defines.svh"
module ccs_div #(
  parameter int unsigned NumW = 64,
  parameter int unsigned DenW = 17
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [NumW-1:0]  num_i,
  input  wire logic [DenW-1:0]  den_i,
  output ccs_pkg::div_ctrl_t    ctrl_o,
  output logic [NumW-1:0]       quo_o
);
  localparam int unsigned CntW = $clog2(NumW + 1);
  logic [NumW-1:0] quo_q, quo_d;
  logic [DenW:0]   rem_q, rem_d;
  logic [DenW-1:0] den_q, den_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic [DenW:0]   trial;

  always_comb begin
    quo_d = quo_q;
    rem_d = rem_q;
    den_d = den_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    trial = {rem_q[DenW-1:0], quo_q[NumW-1]};
    if (start_i) begin
      quo_d = num_i;
      rem_d = '0;
      den_d = den_i;
      cnt_d = CntW'(NumW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quo_d = {quo_q[NumW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[NumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign ctrl_o.start = start_i;
  assign ctrl_o.busy = busy_q;
  assign quo_o = quo_q;

  `CCS_ASSERT_NEXT(a_div_start, clk_i, rst_ni, start_i, busy_q, "divider did not start")
  `CCS_ASSERT(a_div_cnt, clk_i, rst_ni, busy_q || cnt_q == '0, "divider count stale")
endmodule
`default_nettype wire

>>> design/centroid_cross_segment_snap.sv
// ----------------------------------------------------------------------------
// centroid_cross_segment_snap
// Polygon centroid, cross segment through it, endpoints snapped to vertices.
// ----------------------------------------------------------------------------
// Vertices arrive on the in channel (valid/ready), one transaction each, and
// are taken one per cycle while the block is idle; beyond MaxPoints they are
// still taken but discarded and the dropped flag is raised for that polygon.
// A transaction with final_point set starts the solve: the block drops ready,
// runs the two centroid divisions on one shared bit-serial divider, then
// walks the stored vertices once per endpoint through the RAM read port and
// one distance unit. Two results follow on the out channel, start endpoint
// then end endpoint; a stalled receiver holds the result register and the
// block waits. Configuration writes land at once on the cfg channel. Reset
// clears the count, sums and flags and restores heading 0 and half length
// 1.0; the vertex store needs no clearing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "centroid_cross_segment_snap_defines.svh"
module centroid_cross_segment_snap #(
  parameter int unsigned MaxPoints = ccs_pkg::MaxPointsDef,
  parameter int unsigned SineDepth = ccs_pkg::SineDepthDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic signed [31:0] point_x_i,
  input  wire logic signed [31:0] point_y_i,
  input  wire logic signed [31:0] point_z_i,
  input  wire logic               final_point_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic signed [31:0]      snap_x_o,
  output logic signed [31:0]      snap_y_o,
  output logic signed [31:0]      snap_z_o,
  output logic                    segment_end_o,
  output logic                    dropped_o,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [0:0]         cfg_index_i,
  input  wire logic [31:0]        cfg_data_i
);
  localparam int unsigned AddrW = $clog2(MaxPoints);
  localparam int unsigned CntW = $clog2(MaxPoints + 1);
  localparam int unsigned SumW = ccs_pkg::SumW;
  localparam int unsigned TabW = $clog2(SineDepth);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StDivX = 3'd1;
  localparam logic [2:0] StDivY = 3'd2;
  localparam logic [2:0] StPts  = 3'd3;
  localparam logic [2:0] StWalk = 3'd4;
  localparam logic [2:0] StOut  = 3'd5;

  logic [2:0]            state_q, state_d;
  logic [15:0]           heading_q;
  logic [23:0]           half_len_q;
  logic signed [SumW-1:0] sum_x_q, sum_y_q;
  logic [CntW-1:0]       count_q;
  logic                  ovf_q;
  logic                  div_go_q;
  logic                  seg_q;
  logic signed [31:0]    cx_q, cy_q;
  logic signed [31:0]    px_q, py_q;
  logic [CntW-1:0]       idx_q;
  logic                  rd_vld_q;
  logic                  have_q;
  logic [64:0]           best_d_q;
  logic signed [31:0]    bx_q, by_q, bz_q;
  logic signed [31:0]    ox_q, oy_q;

  logic in_acc, store_ok;
  logic [AddrW-1:0] ram_addr;
  logic [31:0] rx, ry, rz;
  ccs_pkg::div_ctrl_t div_ctrl;
  logic [SumW-1:0] div_num, div_quo;
  logic div_neg_q;

  assign in_ready_o = (state_q == StIdle) && !out_valid_o;
  assign cfg_ready_o = 1'b1;
  assign in_acc = in_valid_i && in_ready_o;
  assign store_ok = count_q < CntW'(MaxPoints);
  assign ram_addr = (state_q == StIdle) ? count_q[AddrW-1:0] : idx_q[AddrW-1:0];

  ccs_ram #(.Width(32), .Depth(MaxPoints)) u_ram_x (
    .clk_i, .we_i(in_acc && store_ok), .addr_i(ram_addr),
    .wdata_i(point_x_i), .rdata_o(rx));
  ccs_ram #(.Width(32), .Depth(MaxPoints)) u_ram_y (
    .clk_i, .we_i(in_acc && store_ok), .addr_i(ram_addr),
    .wdata_i(point_y_i), .rdata_o(ry));
  ccs_ram #(.Width(32), .Depth(MaxPoints)) u_ram_z (
    .clk_i, .we_i(in_acc && store_ok), .addr_i(ram_addr),
    .wdata_i(point_z_i), .rdata_o(rz));

  logic signed [SumW-1:0] div_src;
  assign div_src = (state_q == StDivX) ? sum_x_q : sum_y_q;
  assign div_num = div_src[SumW-1] ? SumW'(-div_src) : SumW'(div_src);

  ccs_div #(.NumW(SumW), .DenW(CntW)) u_div (
    .clk_i, .rst_ni, .start_i(div_go_q), .num_i(div_num), .den_i(count_q),
    .ctrl_o(div_ctrl), .quo_o(div_quo));

  // Constant full-turn sine table.
  logic signed [17:0] sin_tab [SineDepth];
  for (genvar g = 0; g < SineDepth; g++) begin : g_sin
    assign sin_tab[g] = ccs_pkg::sine_entry(g, SineDepth);
  end

  // Offset: direction times half length, rounded with ties away from zero.
  logic [15:0] perp, perp_dx;
  logic [TabW-1:0] dx_ix, dy_ix;
  logic signed [17:0] dx_s, dy_s;
  logic [41:0] mx, my;
  logic [41:0] rxo, ryo;
  assign perp = heading_q + 16'd16384;
  assign perp_dx = perp + 16'd16384;
  assign dx_ix = TabW'((32'(perp_dx) * SineDepth) >> 16);
  assign dy_ix = TabW'((32'(perp) * SineDepth) >> 16);
  assign dx_s = sin_tab[dx_ix];
  assign dy_s = sin_tab[dy_ix];
  assign mx = 42'(dx_s[17] ? 18'(-dx_s) : 18'(dx_s)) * 42'(half_len_q);
  assign my = 42'(dy_s[17] ? 18'(-dy_s) : 18'(dy_s)) * 42'(half_len_q);
  assign rxo = (mx + 42'd32768) >> 16;
  assign ryo = (my + 42'd32768) >> 16;

  function automatic logic signed [31:0] sat(input logic signed [33:0] v);
    if (v > 34'sd2147483647) return 32'sh7fffffff;
    if (v < -34'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  logic signed [33:0] ax, ay;
  assign ax = seg_q ? 34'(cx_q) - 34'(ox_q) : 34'(cx_q) + 34'(ox_q);
  assign ay = seg_q ? 34'(cy_q) - 34'(oy_q) : 34'(cy_q) + 34'(oy_q);

  // Distance unit: one vertex a cycle from the RAM read port.
  logic signed [32:0] ddx, ddy;
  logic [32:0] ux, uy;
  logic [64:0] dist_sq;
  assign ddx = 33'(px_q) - 33'($signed(rx));
  assign ddy = 33'(py_q) - 33'($signed(ry));
  assign ux = ddx[32] ? 33'(-ddx) : 33'(ddx);
  assign uy = ddy[32] ? 33'(-ddy) : 33'(ddy);
  assign dist_sq = 65'(ux[31:0]) * 65'(ux[31:0]) + 65'(uy[31:0]) * 65'(uy[31:0])
                 + (ux[32] ? 65'h1_0000_0000 * 65'(ux[31:0]) : '0);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (in_acc && final_point_i) state_d = StDivX;
      StDivX: if (!div_go_q && !div_ctrl.busy) state_d = StDivY;
      StDivY: if (!div_go_q && !div_ctrl.busy) state_d = StPts;
      StPts:  state_d = StWalk;
      StWalk: if (idx_q >= count_q && !rd_vld_q) state_d = StOut;
      StOut:  if (!out_valid_o) state_d = seg_q ? StIdle : StPts;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      heading_q <= '0;
      half_len_q <= 24'd65536;
      sum_x_q <= '0;
      sum_y_q <= '0;
      count_q <= '0;
      ovf_q <= 1'b0;
      div_go_q <= 1'b0;
      seg_q <= 1'b0;
      idx_q <= '0;
      rd_vld_q <= 1'b0;
      have_q <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      div_go_q <= (state_q == StIdle && in_acc && final_point_i) ||
                  (state_q == StDivX && !div_go_q && !div_ctrl.busy);
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          ccs_pkg::RegHeading: heading_q <= cfg_data_i[15:0];
          ccs_pkg::RegHalfLen: half_len_q <= cfg_data_i[23:0];
          default: ;
        endcase
      end
      if (out_valid_o && out_ready_i) out_valid_o <= 1'b0;
      unique case (state_q)
        StIdle: begin
          if (in_acc) begin
            if (store_ok) begin
              sum_x_q <= sum_x_q + SumW'(point_x_i);
              sum_y_q <= sum_y_q + SumW'(point_y_i);
              count_q <= count_q + 1'b1;
            end else begin
              ovf_q <= 1'b1;
            end
            if (final_point_i) begin
              seg_q <= 1'b0;
            end
          end
        end
        StDivX: begin
          if (!div_go_q && !div_ctrl.busy) begin
            cx_q <= div_neg_q ? -32'(div_quo) : 32'(div_quo);
          end
        end
        StDivY: begin
          if (!div_go_q && !div_ctrl.busy) begin
            cy_q <= div_neg_q ? -32'(div_quo) : 32'(div_quo);
          end
        end
        StPts: begin
          px_q <= sat(ax);
          py_q <= sat(ay);
          idx_q <= '0;
          rd_vld_q <= 1'b0;
          have_q <= 1'b0;
        end
        StWalk: begin
          rd_vld_q <= idx_q < count_q;
          if (idx_q < count_q) idx_q <= idx_q + 1'b1;
          if (rd_vld_q && (!have_q || dist_sq < best_d_q)) have_q <= 1'b1;
          if (idx_q >= count_q && !rd_vld_q) out_valid_o <= 1'b1;
        end
        StOut: begin
          if (!out_valid_o) begin
            seg_q <= 1'b1;
            if (seg_q) begin
              sum_x_q <= '0;
              sum_y_q <= '0;
              count_q <= '0;
              ovf_q <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_go_q) div_neg_q <= div_src[SumW-1];
    if (state_q == StDivX) begin
      ox_q <= dx_s[17] ? -32'(rxo) : 32'(rxo);
      oy_q <= dy_s[17] ? -32'(ryo) : 32'(ryo);
    end
    if (state_q == StWalk && rd_vld_q && (!have_q || dist_sq < best_d_q)) begin
      best_d_q <= dist_sq;
      bx_q <= rx;
      by_q <= ry;
      bz_q <= rz;
    end
    if (state_q == StWalk && idx_q >= count_q && !rd_vld_q) begin
      snap_x_o <= have_q ? bx_q : px_q;
      snap_y_o <= have_q ? by_q : py_q;
      snap_z_o <= have_q ? bz_q : 32'sd0;
      segment_end_o <= seg_q;
      dropped_o <= ovf_q;
    end
  end

  `CCS_ASSERT(a_ready_idle, clk_i, rst_ni, !in_ready_o || state_q == StIdle, "ready not idle")
  `CCS_ASSERT(a_count_max, clk_i, rst_ni, count_q <= CntW'(MaxPoints), "count past capacity")
  `CCS_ASSERT_NEXT(a_final_go, clk_i, rst_ni, in_acc && final_point_i, state_q == StDivX, "no solve")
  `CCS_ASSERT(a_out_state, clk_i, rst_ni, !out_valid_o || state_q == StOut, "result not in output")
endmodule
`default_nettype wire

>>> test/testbench.sv
// ----------------------------------------------------------------------------
// Testbench for centroid_cross_segment_snap
// Streams polygons through the block under several heading and half length
// settings and idle patterns, predicts both snapped endpoints of each
// polygon independently and compares every result transaction field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module testbench;

  localparam int Capacity = ccs_pkg::MaxPointsDef;
  localparam longint CycleLimit = 3000000;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               last;
  } vertex_t;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               seg_end;
    logic               dropped;
  } snap_t;

  logic clk_i, rst_ni;
  logic in_valid_i, in_ready_o, final_point_i;
  logic signed [31:0] point_x_i, point_y_i, point_z_i;
  logic out_valid_o, out_ready_i, segment_end_o, dropped_o;
  logic signed [31:0] snap_x_o, snap_y_o, snap_z_o;
  logic cfg_valid_i, cfg_ready_o;
  logic [0:0] cfg_index_i;
  logic [31:0] cfg_data_i;

  centroid_cross_segment_snap uut (.*);

  vertex_t pending_vertices[$];
  snap_t expected_snaps[$];
  int error_count = 0;
  int in_idle_pct = 0, out_stall_pct = 0;
  bit in_taken = 0, cfg_taken = 0;
  longint cycle_count = 0;

  logic [31:0] poly_x[Capacity], poly_y[Capacity], poly_z[Capacity];
  longint sum_x = 0, sum_y = 0;
  int vertex_count = 0;
  bit overflow_seen = 0;
  logic [15:0] heading = 0;
  logic [23:0] half_length = 24'd65536;

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic report(input string what, input longint got, input longint want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  task automatic queue_vertex(input vertex_t v);
    pending_vertices = {pending_vertices, v};
  endtask

  function automatic longint quarter_sine(input int unsigned u);
    longint unsigned x, x2, term;
    longint acc;
    longint unsigned r;
    x = (longint'(u) * 64'd3373259426) >> 15;
    x2 = (x * x) >> 30;
    term = x;
    acc = x;
    for (int n = 1; n <= 7; n++) begin
      term = ((term * x2) >> 30) / ((2 * n) * (2 * n + 1));
      if (n % 2 == 1) acc -= term;
      else acc += term;
    end
    if (acc < 0) acc = 0;
    r = (longint'(acc) + 8192) >> 14;
    if (r > 65536) r = 65536;
    return r;
  endfunction

  function automatic longint heading_sine(input logic [15:0] a);
    logic [15:0] t;
    longint m;
    t = {a[15:8], 8'd0};
    m = t[14] ? quarter_sine(16384 - t[13:0]) : quarter_sine(t[13:0]);
    return t[15] ? -m : m;
  endfunction

  function automatic longint scale_offset(input longint d, input longint hl);
    longint r;
    r = ((d < 0 ? -d : d) * hl + 32768) >>> 16;
    return d < 0 ? -r : r;
  endfunction

  function automatic longint centroid_of(input longint s, input int n);
    longint q;
    q = (s < 0 ? -s : s) / n;
    return s < 0 ? -q : q;
  endfunction

  function automatic longint sat32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic snap_t nearest_vertex(input longint px, input longint py,
                                           input logic seg_end);
    snap_t s;
    logic [64:0] d, best_d;
    longint ddx, ddy;
    logic [32:0] ux, uy;
    int best;
    best = 0;
    best_d = '1;
    for (int i = 0; i < vertex_count; i++) begin
      ddx = px - longint'($signed(poly_x[i]));
      ddy = py - longint'($signed(poly_y[i]));
      ux = ddx < 0 ? -ddx : ddx;
      uy = ddy < 0 ? -ddy : ddy;
      d = 65'(ux) * 65'(ux) + 65'(uy) * 65'(uy);
      if (i == 0 || d < best_d) begin
        best_d = d;
        best = i;
      end
    end
    s.x = poly_x[best];
    s.y = poly_y[best];
    s.z = poly_z[best];
    s.seg_end = seg_end;
    s.dropped = overflow_seen;
    return s;
  endfunction

  task automatic predict_vertex(input vertex_t v);
    longint cx, cy, ox, oy;
    logic [15:0] p;
    if (vertex_count < Capacity) begin
      poly_x[vertex_count] = v.x;
      poly_y[vertex_count] = v.y;
      poly_z[vertex_count] = v.z;
      sum_x += v.x;
      sum_y += v.y;
      vertex_count++;
    end else begin
      overflow_seen = 1;
    end
    if (v.last) begin
      cx = centroid_of(sum_x, vertex_count);
      cy = centroid_of(sum_y, vertex_count);
      p = heading + 16'd16384;
      ox = scale_offset(heading_sine(p + 16'd16384), half_length);
      oy = scale_offset(heading_sine(p), half_length);
      expected_snaps = {expected_snaps,
                        nearest_vertex(sat32(cx + ox), sat32(cy + oy), 1'b0)};
      expected_snaps = {expected_snaps,
                        nearest_vertex(sat32(cx - ox), sat32(cy - oy), 1'b1)};
      sum_x = 0;
      sum_y = 0;
      vertex_count = 0;
      overflow_seen = 0;
    end
  endtask

  always @(posedge clk_i) begin
    snap_t e;
    cycle_count++;
    in_taken = in_valid_i && in_ready_o;
    cfg_taken = cfg_valid_i && cfg_ready_o;
    if (cfg_taken) begin
      if (cfg_index_i == ccs_pkg::RegHeading) heading = cfg_data_i[15:0];
      else half_length = cfg_data_i[23:0];
    end
    if (in_taken)
      predict_vertex('{point_x_i, point_y_i, point_z_i, final_point_i});
    if (out_valid_o && out_ready_i) begin
      if (expected_snaps.size() == 0) begin
        report("unexpected result", snap_x_o, 0);
      end else begin
        e = expected_snaps.pop_front();
        if (snap_x_o !== e.x) report("snap_x", snap_x_o, e.x);
        if (snap_y_o !== e.y) report("snap_y", snap_y_o, e.y);
        if (snap_z_o !== e.z) report("snap_z", snap_z_o, e.z);
        if (segment_end_o !== e.seg_end) report("segment_end", segment_end_o, e.seg_end);
        if (dropped_o !== e.dropped) report("dropped", dropped_o, e.dropped);
      end
    end
    if (cycle_count > CycleLimit) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    vertex_t v;
    if (rst_ni) begin
      out_ready_i <= ($urandom_range(99) >= out_stall_pct);
      if (!in_valid_i || in_taken) begin
        if (pending_vertices.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
          v = pending_vertices.pop_front();
          in_valid_i <= 1'b1;
          point_x_i <= v.x;
          point_y_i <= v.y;
          point_z_i <= v.z;
          final_point_i <= v.last;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  function automatic logic [31:0] rand_coord(input int style);
    case (style)
      0: return $urandom;
      1: return $signed($urandom_range(4000)) - 2000;
      2: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
      default: return $signed($urandom_range(1 << 22)) - (1 << 21);
    endcase
  endfunction

  task automatic add_polygon(input int n, input int style);
    vertex_t v;
    for (int i = 0; i < n; i++) begin
      v.x = rand_coord(style);
      v.y = rand_coord(style);
      v.z = $urandom;
      v.last = (i == n - 1);
      queue_vertex(v);
    end
  endtask

  task automatic wait_drained();
    while (pending_vertices.size() != 0 || in_valid_i || expected_snaps.size() != 0)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [31:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!(cfg_valid_i && cfg_ready_o));
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    vertex_t v;
    int budget;
    rst_ni = 0;
    in_valid_i = 0;
    point_x_i = 0;
    point_y_i = 0;
    point_z_i = 0;
    final_point_i = 0;
    out_ready_i = 0;
    cfg_valid_i = 0;
    cfg_index_i = ccs_pkg::RegHeading;
    cfg_data_i = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;

    queue_vertex('{32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1'b1});
    queue_vertex('{32'h80000000, 32'h80000000, 32'h80000000, 1'b1});
    queue_vertex('{32'h7fffffff, 32'h80000000, 32'h0, 1'b0});
    queue_vertex('{32'h80000000, 32'h7fffffff, 32'hffffffff, 1'b1});
    for (int i = 0; i < 4; i++)
      queue_vertex('{32'h10000, 32'h0, 32'(i), 1'b0});
    queue_vertex('{-32'sh10000, 32'h0, 32'h55, 1'b0});
    queue_vertex('{-32'sh10000, 32'h0, 32'h66, 1'b1});
    queue_vertex('{32'h0, 32'h0, 32'h1, 1'b0});
    queue_vertex('{32'h0, 32'h0, 32'h2, 1'b0});
    queue_vertex('{32'h0, 32'h0, 32'h3, 1'b1});
    add_polygon(5, 1);
    wait_drained();

    for (int phase = 0; phase < 12; phase++) begin
      case (phase % 4)
        0: begin in_idle_pct = 0; out_stall_pct = 0; end
        1: begin in_idle_pct = 76; out_stall_pct = 0; end
        2: begin in_idle_pct = 0; out_stall_pct = 76; end
        default: begin in_idle_pct = 31; out_stall_pct = 31; end
      endcase
      case (phase)
        0: begin
          write_reg(ccs_pkg::RegHeading, 32'h0000ffff);
          write_reg(ccs_pkg::RegHalfLen, 32'h00800000);
        end
        1: begin
          write_reg(ccs_pkg::RegHeading, 32'h0);
          write_reg(ccs_pkg::RegHalfLen, 32'h0);
        end
        2: begin
          write_reg(ccs_pkg::RegHeading, 32'h4000);
          write_reg(ccs_pkg::RegHalfLen, 32'hff000001);
        end
        3: begin
          write_reg(ccs_pkg::RegHeading, 32'hffff8000);
          write_reg(ccs_pkg::RegHalfLen, 32'h10000);
        end
        default: begin
          write_reg(ccs_pkg::RegHeading, $urandom);
          write_reg(ccs_pkg::RegHalfLen,
                    {8'($urandom_range(255)), 24'($urandom_range(24'h800000))});
        end
      endcase
      if (phase == 6) add_polygon(Capacity + 3, 3);
      budget = 60;
      while (budget > 0) begin
        v.x = $urandom_range(11) + 1;
        add_polygon(v.x, $urandom_range(3));
        budget -= v.x;
      end
      wait_drained();
    end

    repeat (100) @(posedge clk_i);
    if (error_count == 0 && expected_snaps.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
